// File: rtl/ipmd_pkg.sv
package ipmd_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_GAIN_P     = 3'd0;
  localparam logic [2:0] REG_GAIN_I     = 3'd1;
  localparam logic [2:0] REG_GAIN_D     = 3'd2;
  localparam logic [2:0] REG_SEP_THRESH = 3'd3;
  localparam logic [2:0] REG_DRV_LIMIT  = 3'd4;
  localparam logic [2:0] REG_GATE_ROW   = 3'd5;

  // Reset values
  localparam logic [15:0] SEP_THRESH_RST = 16'd115;
  localparam logic [14:0] DRV_LIMIT_RST  = 15'd8000;
  localparam logic [7:0]  GATE_ROW_RST   = 8'd38;

  // Field widths
  localparam int unsigned SPEED_W = 16;
  localparam int unsigned ROW_W   = 8;
  localparam int unsigned DUTY_W  = 15;
  localparam int unsigned ERR_W   = 17;
  localparam int unsigned ACC_W   = 24;

  typedef struct packed {
    logic signed [15:0] gain_p;
    logic signed [15:0] gain_i;
    logic signed [15:0] gain_d;
    logic [15:0]        sep_thresh;
    logic [14:0]        drive_limit;
    logic [7:0]         gate_row;
  } cfg_t;

endpackage

// File: rtl/incremental_pid_motor_drive.sv
// Incremental PID speed loop with integral separation. Each input beat is one
// control tick: the error (target_speed - measured_pulses) is pushed into a
// three-deep history, P/I/D increments are formed from Q8.8 gains and added to
// a drive accumulator with 8 fractional bits (only P when the previous error
// magnitude is at or above separation_threshold), and the accumulator clamps at
// +/- drive_limit. The result beat carries the integer duty on the forward or
// reverse channel by sign; both are zero when image_start_row > gate_row or
// triangle_flag is set, and clear_target follows wide_lane_flag unless gated.
// Throughput is one beat per clock while out_tready does not stall the pipe; the
// difference stage loads at accept, then the multiply stage, then the accumulate
// stage registers the result, and the accumulator feedback closes in the single
// accumulate/clamp stage. Config is written through cfg_we/cfg_addr/cfg_wdata;
// the user must write it while the pipe is empty, as the block has no check for this.
module incremental_pid_motor_drive (
  input  logic        clk,
  input  logic        rst_n,
  // config write port
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [15:0] cfg_wdata,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [15:0] target_speed, [31:16] measured_pulses,
                                  // [39:32] image_start_row
  input  logic [1:0]  in_tuser,   // [0] wide_lane_flag, [1] triangle_flag
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [14:0] forward_duty, [29:15] reverse_duty,
                                  // [31:30] zero
  output logic [0:0]  out_tuser   // [0] clear_target
);

  ipmd_pkg::cfg_t cfg_r;

  // register file; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_p      <= '0;
      cfg_r.gain_i      <= '0;
      cfg_r.gain_d      <= '0;
      cfg_r.sep_thresh  <= ipmd_pkg::SEP_THRESH_RST;
      cfg_r.drive_limit <= ipmd_pkg::DRV_LIMIT_RST;
      cfg_r.gate_row    <= ipmd_pkg::GATE_ROW_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        ipmd_pkg::REG_GAIN_P:     cfg_r.gain_p      <= cfg_wdata;
        ipmd_pkg::REG_GAIN_I:     cfg_r.gain_i      <= cfg_wdata;
        ipmd_pkg::REG_GAIN_D:     cfg_r.gain_d      <= cfg_wdata;
        ipmd_pkg::REG_SEP_THRESH: cfg_r.sep_thresh  <= cfg_wdata;
        ipmd_pkg::REG_DRV_LIMIT:  cfg_r.drive_limit <= cfg_wdata[14:0];
        ipmd_pkg::REG_GATE_ROW:   cfg_r.gate_row    <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  logic [14:0] fwd, rev;
  logic        clr;

  ipmd_pipe u_pipe (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .in_valid        (in_tvalid),
    .in_ready        (in_tready),
    .target_speed    ($signed(in_tdata[15:0])),
    .measured_pulses ($signed(in_tdata[31:16])),
    .image_start_row (in_tdata[39:32]),
    .wide_lane_flag  (in_tuser[0]),
    .triangle_flag   (in_tuser[1]),
    .out_valid       (out_tvalid),
    .out_ready       (out_tready),
    .forward_duty    (fwd),
    .reverse_duty    (rev),
    .clear_target    (clr)
  );

  assign out_tdata = {2'b00, rev, fwd};
  assign out_tuser = clr;

endmodule

// File: rtl/ipmd_pipe.sv
module ipmd_pipe (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  ipmd_pkg::cfg_t                       cfg,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [ipmd_pkg::SPEED_W-1:0]  target_speed,
  input  logic signed [ipmd_pkg::SPEED_W-1:0]  measured_pulses,
  input  logic [ipmd_pkg::ROW_W-1:0]           image_start_row,
  input  logic                                 wide_lane_flag,
  input  logic                                 triangle_flag,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [ipmd_pkg::DUTY_W-1:0]          forward_duty,
  output logic [ipmd_pkg::DUTY_W-1:0]          reverse_duty,
  output logic                                 clear_target
);

  // ---------------- handshake chain ----------------
  logic v1_r, v2_r, out_v_r;
  logic rdy1, rdy2, rdy3;
  logic in_acc, mv12, mv23;

  assign rdy3     = !out_v_r || out_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;
  assign in_acc   = in_valid && rdy1;
  assign mv12     = v1_r && rdy2;
  assign mv23     = v2_r && rdy3;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      v1_r    <= in_acc || (v1_r && !rdy2);
      v2_r    <= mv12 || (v2_r && !rdy3);
      out_v_r <= mv23 || (out_v_r && !out_ready);
    end
  end

  assign out_valid = out_v_r;

  // ---------------- error history, updated at accept ----------------
  logic signed [16:0] e_now_r, e_last_r, e_bl_r;
  logic signed [16:0] e_new;
  logic signed [17:0] dp_nxt;
  logic signed [18:0] dd_nxt;
  logic [16:0]        mag_now;
  logic               sep_nxt;

  assign e_new  = {target_speed[15], target_speed} - {measured_pulses[15], measured_pulses};
  assign dp_nxt = {e_new[16], e_new} - {e_now_r[16], e_now_r};
  // e_new - 2*e_now + e_last
  assign dd_nxt = {{2{e_new[16]}}, e_new} - {e_now_r[16], e_now_r, 1'b0}
                + {{2{e_last_r[16]}}, e_last_r};
  // e_now becomes e_last for this beat
  assign mag_now = e_now_r[16] ? 17'(-e_now_r) : e_now_r;
  assign sep_nxt = mag_now < {1'b0, cfg.sep_thresh};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_now_r  <= '0;
      e_last_r <= '0;
      e_bl_r   <= '0;
    end else if (in_acc) begin
      e_bl_r   <= e_last_r;
      e_last_r <= e_now_r;
      e_now_r  <= e_new;
    end
  end

  // ---------------- stage 1: differences and flags ----------------
  logic signed [16:0] e1_r;
  logic signed [17:0] dp1_r;
  logic signed [18:0] dd1_r;
  logic               sep1_r, clr1_r, zero1_r;
  logic               gated;

  assign gated = image_start_row > cfg.gate_row;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      e1_r    <= e_new;
      dp1_r   <= dp_nxt;
      dd1_r   <= dd_nxt;
      sep1_r  <= sep_nxt;
      clr1_r  <= !gated && wide_lane_flag;
      zero1_r <= gated || triangle_flag;
    end
  end

  // ---------------- stage 2: products ----------------
  logic signed [33:0] p2_r, p_nxt;
  logic signed [32:0] i2_r, i_nxt;
  logic signed [34:0] d2_r, d_nxt;
  logic               clr2_r, zero2_r;

  assign p_nxt = $signed(cfg.gain_p) * dp1_r;
  assign i_nxt = $signed(cfg.gain_i) * e1_r;
  assign d_nxt = $signed(cfg.gain_d) * dd1_r;

  always_ff @(posedge clk) begin
    if (mv12) begin
      p2_r    <= p_nxt;
      // integral separation: only P when the last error is large
      i2_r    <= sep1_r ? i_nxt : '0;
      d2_r    <= sep1_r ? d_nxt : '0;
      clr2_r  <= clr1_r;
      zero2_r <= zero1_r;
    end
  end

  // ---------------- stage 3: accumulate, clamp, split by sign ----------------
  localparam int unsigned ACC_W_L = ipmd_pkg::ACC_W;
  logic signed [ACC_W_L-1:0] acc_r, acc_nxt;
  logic signed [37:0] sum, bound, clamped;
  logic [23:0]        acc_mag;
  logic [14:0]        fwd_r, rev_r;
  logic               clr_r;

  assign sum     = 38'(acc_r) + 38'(p2_r) + 38'(i2_r) + 38'(d2_r);
  assign bound   = $signed({15'd0, cfg.drive_limit, 8'd0});
  assign clamped = (sum > bound) ? bound : ((sum < -bound) ? -bound : sum);
  assign acc_nxt = clamped[23:0];
  assign acc_mag = acc_nxt[23] ? 24'(-acc_nxt) : acc_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (mv23) begin
      acc_r <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mv23) begin
      fwd_r <= (!zero2_r && !acc_nxt[23]) ? acc_mag[22:8] : '0;
      rev_r <= (!zero2_r && acc_nxt[23]) ? acc_mag[22:8] : '0;
      clr_r <= clr2_r;
    end
  end

  assign forward_duty = fwd_r;
  assign reverse_duty = rev_r;
  assign clear_target = clr_r;

  // ---------------- assertions ----------------
  a_one_channel: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (fwd_r == '0 || rev_r == '0))
    else $error("both duty channels active");

  a_acc_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !mv23 |=> $stable(acc_r))
    else $error("accumulator moved without a result load");

  a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && !rdy3) |=> (v2_r && $stable(p2_r) && $stable(d2_r)))
    else $error("stage 2 lost a stalled beat");

  a_hist_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !in_acc |=> $stable(e_now_r) && $stable(e_last_r))
    else $error("error history shifted without an accept");

endmodule

// File: verif/incremental_pid_motor_drive_tb.sv
`timescale 1ns / 1ps

module incremental_pid_motor_drive_tb;

  // Idling schemes, one per phase
  typedef enum logic [1:0] {
    IDLE_NONE = 2'd0,
    IDLE_SEND = 2'd1,
    IDLE_RECV = 2'd2,
    IDLE_BOTH = 2'd3
  } idle_t;

  // One control tick as it goes into the block
  typedef struct packed {
    logic signed [15:0] target;
    logic signed [15:0] measured;
    logic [7:0]         row;
    logic               wide_lane;
    logic               triangle;
  } tick_t;

  // Duties and clear flag coming back for one tick
  typedef struct packed {
    logic [14:0] fwd;
    logic [14:0] rev;
    logic        clr;
  } duty_t;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        cfg_we    = 1'b0;
  logic [2:0]  cfg_addr  = '0;
  logic [15:0] cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata  = '0;  // [15:0] target_speed, [31:16] measured_pulses,
                                // [39:32] image_start_row
  logic [1:0]  in_tuser  = '0;  // [0] wide_lane_flag, [1] triangle_flag
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;       // [14:0] forward_duty, [29:15] reverse_duty
  logic [0:0]  out_tuser;       // [0] clear_target

  incremental_pid_motor_drive u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Loop model: register copies, as they stand after reset
  logic signed [15:0] kp      = '0;
  logic signed [15:0] ki      = '0;
  logic signed [15:0] kd      = '0;
  logic [15:0]        sep_thr = ipmd_pkg::SEP_THRESH_RST;
  logic [14:0]        lim     = ipmd_pkg::DRV_LIMIT_RST;
  logic [7:0]         gate    = ipmd_pkg::GATE_ROW_RST;

  // Loop model: error history and drive accumulator (8 fractional bits)
  logic signed [16:0] err_now_m  = '0;
  logic signed [16:0] err_last_m = '0;
  logic signed [16:0] err_prev_m = '0;
  logic signed [23:0] accum_m    = '0;

  tick_t tick_q[$];    // ticks waiting to be sent
  duty_t duty_q[$];    // predicted duties, oldest first
  tick_t held;         // tick currently on the input bus
  duty_t want;
  idle_t idle_mode = IDLE_NONE;
  int    err_count = 0;

  // One control tick of the speed loop; advances the model state.
  function automatic duty_t pid_tick(tick_t t);
    longint e0, e1, e2, p, i, d, sum, bound, mag;
    duty_t  r;
    e2 = longint'(err_last_m);
    e1 = longint'(err_now_m);
    e0 = longint'($signed(t.target)) - longint'($signed(t.measured));
    p = longint'(kp) * (e0 - e1);
    i = longint'(ki) * e0;
    d = longint'(kd) * (e0 - 2 * e1 + e2);
    // integral separation: I and D only while the last error is small
    mag = (e1 < 0) ? -e1 : e1;
    sum = longint'(accum_m) + p;
    if (mag < longint'(sep_thr))
      sum = sum + i + d;
    bound = longint'(lim) * 256;
    if (sum > bound)
      sum = bound;
    if (sum < -bound)
      sum = -bound;
    accum_m    = sum[23:0];
    err_prev_m = err_last_m;
    err_last_m = err_now_m;
    err_now_m  = e0[16:0];
    r = '0;
    // gated off above the row; triangle kills only the duties
    if (t.row <= gate) begin
      r.clr = t.wide_lane;
      if (!t.triangle) begin
        if (sum >= 0)
          r.fwd = 15'(sum / 256);
        else
          r.rev = 15'((-sum) / 256);
      end
    end
    return r;
  endfunction

  function automatic bit hold_off(bit on);
    int pct;
    pct = (idle_mode == IDLE_BOTH) ? 7 : 78;
    return on && ($urandom_range(99) < pct);
  endfunction

  task automatic report(string what, int got, int exp_val);
    $display("MISMATCH %s: got %0d, expected %0d", what, got, exp_val);
    err_count++;
  endtask

  // Driver: predict on every accepted beat, refill from tick_q
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready)
        duty_q.push_back(pid_tick(held));
      if (!in_tvalid || in_tready) begin
        if (tick_q.size() != 0 &&
            !hold_off(idle_mode == IDLE_SEND || idle_mode == IDLE_BOTH)) begin
          held = tick_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {held.row, held.measured, held.target};
          in_tuser  <= {held.triangle, held.wide_lane};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result beat with the oldest prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (duty_q.size() == 0) begin
          report("result beat with nothing pending", int'(out_tdata), 0);
        end else begin
          want = duty_q.pop_front();
          if (out_tdata[14:0] !== want.fwd)
            report("forward_duty", int'(out_tdata[14:0]), int'(want.fwd));
          if (out_tdata[29:15] !== want.rev)
            report("reverse_duty", int'(out_tdata[29:15]), int'(want.rev));
          if (out_tuser[0] !== want.clr)
            report("clear_target", int'(out_tuser[0]), int'(want.clr));
        end
      end
      out_tready <= !hold_off(idle_mode == IDLE_RECV || idle_mode == IDLE_BOTH);
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    case (idx)
      ipmd_pkg::REG_GAIN_P:     kp      = val;
      ipmd_pkg::REG_GAIN_I:     ki      = val;
      ipmd_pkg::REG_GAIN_D:     kd      = val;
      ipmd_pkg::REG_SEP_THRESH: sep_thr = val;
      ipmd_pkg::REG_DRV_LIMIT:  lim     = val[14:0];
      ipmd_pkg::REG_GATE_ROW:   gate    = val[7:0];
      default: ;
    endcase
  endtask

  task automatic load_cfg(logic [15:0] p, logic [15:0] i, logic [15:0] d,
                          logic [15:0] thr, logic [15:0] limit, logic [15:0] row);
    write_reg(ipmd_pkg::REG_GAIN_P, p);
    write_reg(ipmd_pkg::REG_GAIN_I, i);
    write_reg(ipmd_pkg::REG_GAIN_D, d);
    write_reg(ipmd_pkg::REG_SEP_THRESH, thr);
    write_reg(ipmd_pkg::REG_DRV_LIMIT, limit);
    write_reg(ipmd_pkg::REG_GATE_ROW, row);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic add_tick(int tgt, int meas, int row, bit wide, bit tri_f);
    tick_t t;
    t.target    = 16'(tgt);
    t.measured  = 16'(meas);
    t.row       = 8'(row);
    t.wide_lane = wide;
    t.triangle  = tri_f;
    tick_q.push_back(t);
  endtask

  // Random tick: mostly speeds near each other so the error stays in
  // separation range and the accumulator moves; some full-range and corners.
  task automatic add_random_tick();
    int sel, base, tgt, meas, row;
    int corner[4];
    corner = '{32767, -32768, 0, -1};
    sel = $urandom_range(99);
    if (sel < 55) begin
      base = int'($urandom_range(400)) - 200;
      tgt  = base;
      meas = base + int'($urandom_range(300)) - 150;
    end else if (sel < 85) begin
      tgt  = int'($urandom_range(65535));
      meas = int'($urandom_range(65535));
    end else begin
      tgt  = corner[$urandom_range(3)];
      meas = corner[$urandom_range(3)];
    end
    if ($urandom_range(99) < 75)
      row = int'($urandom_range(gate));
    else
      row = int'($urandom_range(255));
    add_tick(tgt, meas, row, $urandom_range(1), $urandom_range(99) < 20);
  endtask

  // Random gains are mostly small so the loop does not just sit at a rail.
  function automatic logic [15:0] rand_gain();
    if ($urandom_range(3) == 0)
      return 16'($urandom);
    return 16'(int'($urandom_range(1024)) - 512);
  endfunction

  // Let everything sent come back, then leave a few idle cycles
  task automatic drain();
    while (tick_q.size() != 0 || in_tvalid || duty_q.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: 1.5 / 0.25 / 0.125 gains, reset threshold, limit and gate row
    load_cfg(16'd384, 16'd64, 16'd32, 16'd115, 16'd8000, 16'd38);
    add_tick(0, 0, 0, 0, 0);                 // zero accumulator
    add_tick(100, 0, 0, 0, 0);
    add_tick(100, -14, 10, 1, 0);            // error just under threshold
    add_tick(50, 0, 38, 0, 0);               // row at gate, full PID
    add_tick(115, 0, 20, 0, 0);              // error at threshold
    add_tick(0, 0, 20, 0, 0);                // previous at threshold: P only
    add_tick(-100, 100, 39, 1, 0);           // gated, row just above gate
    add_tick(-200, 0, 255, 1, 1);            // gated with both flags
    add_tick(-300, 0, 5, 1, 1);              // triangle, clear still passes
    add_tick(-300, 0, 5, 0, 1);
    add_tick(-300, 0, 5, 0, 0);              // reverse channel
    add_tick(32767, -32768, 0, 0, 0);        // largest positive error
    add_tick(32767, -32768, 0, 1, 0);
    add_tick(-32768, 32767, 0, 0, 0);        // largest negative error
    add_tick(-32768, 32767, 0, 0, 0);
    add_tick(0, 0, 0, 0, 0);
    add_tick(-1, 0, 1, 1, 0);
    add_tick(32767, 32767, 38, 1, 0);
    add_tick(-32768, -32768, 255, 0, 1);
    add_tick(5, 3, 0, 0, 0);
    drain();

    // Random phases; idle scheme rotates with the phase number
    for (int k = 1; k <= 9; k++) begin
      idle_mode <= idle_t'(k % 4);
      case (k)
        1: load_cfg(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        2: load_cfg(16'h8000, 16'h8000, 16'h8000, 16'h0000, 16'h0000, 16'h0000);
        3: load_cfg(16'h7FFF, 16'h8000, rand_gain(), 16'($urandom_range(300)),
                    16'h7FFF, 16'($urandom));
        4: load_cfg(rand_gain(), rand_gain(), rand_gain(), 16'h0000,
                    16'($urandom), 16'd255);
        5: load_cfg(rand_gain(), rand_gain(), rand_gain(), 16'hFFFF,
                    16'h8000 | 16'($urandom_range(200)), 16'($urandom));
        default: load_cfg(rand_gain(), rand_gain(), rand_gain(),
                          16'($urandom_range(400)), 16'($urandom),
                          16'($urandom));
      endcase
      repeat (100) add_random_tick();
      drain();
    end

    if (duty_q.size() != 0)
      report("results never seen", 0, duty_q.size());
    if (err_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #5000000;
    $display("simulation failed");
    $finish;
  end

endmodule
